/* src/chol_pkg.sv */
// Shared types and constants for the cell height obstacle labeler.
package chol_pkg;

  localparam int IDX_W   = 14;
  localparam int BEAM_W  = 6;
  localparam int Z_W     = 16;
  localparam int H_W     = 17;
  localparam int CNT_W   = 16;
  localparam int FRAME_W = 16;
  localparam int RANGE_W = 16;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [H_W-1:0] BAND_LOW  = -17'sd250;
  localparam logic signed [H_W-1:0] BAND_HIGH = -17'sd60;
  localparam logic [RANGE_W-1:0]    MIN_RANGE = 16'd100;
  localparam logic [CNT_W:0]        HIT_STEP  = 17'd2;

  localparam logic signed [H_W-1:0] MIN_RESET = 17'sh0FFFF;
  localparam logic signed [H_W-1:0] MAX_RESET = 17'sh10000;

  localparam logic [CFG_W-1:0] OBST_RESET = 10'd30;
  localparam logic [CFG_W-1:0] OVER_RESET = 10'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBSTACLE_HEIGHT = 2'd0,
    REG_OVERPASS_HEIGHT = 2'd1,
    REG_FORCE_OBSTACLE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC
  } back_state_t;

  typedef struct packed {
    logic                    addr_ok;
    logic                    upd_ok;
    logic [IDX_W-1:0]        cell_index;
    logic signed [H_W-1:0]   z;
    logic                    range_ok;
    logic                    pobs;
    logic [FRAME_W-1:0]      frame;
  } point_t;

  typedef struct packed {
    logic signed [H_W-1:0] min_h;
    logic signed [H_W-1:0] max_h;
    logic                  obst;
    logic [FRAME_W-1:0]    last_frame;
    logic [CNT_W-1:0]      hits;
    logic [CNT_W-1:0]      seen;
  } cell_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  localparam cell_t CELL_RESET = '{
    min_h: MIN_RESET, max_h: MAX_RESET, obst: 1'b0,
    last_frame: '1, hits: '0, seen: '0
  };

endpackage

/* src/cell_height_obstacle_labeler_top.sv */
// Top level of the cell height obstacle labeler.
// Points enter on the input channel (in_valid/in_stall); each request carries
// the cell address, beam, height and range of one lidar point.
// Exactly one result leaves on the output channel (out_valid/out_stall) for
// every accepted point, in order, with the cell state after that point.
// Registers are written on the cfg channel, which is always ready; write them
// only while no point is in flight.
// After reset the cell memory is swept to its reset contents, one cell per
// cycle; in_stall stays high during the sweep.
// A point is held in the queue, its cell is read into a register and its
// result is registered. A new point waits for the last: the cell is read in one
// cycle and written back in the next through the single cell memory.
// Up to two points wait in the queue; when the receiver stalls, the result is
// held and the queue fills, after which in_stall rises.
module cell_height_obstacle_labeler_top import chol_pkg::*; #(
  parameter int CELL_COUNT = 16384,
  parameter int BEAM_COUNT = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [IDX_W-1:0]         cell_index,
  input  logic                     cell_found,
  input  logic [BEAM_W-1:0]        beam_number,
  input  logic                     point_valid,
  input  logic signed [Z_W-1:0]    point_z_cm,
  input  logic signed [Z_W-1:0]    vehicle_z_cm,
  input  logic [RANGE_W-1:0]       raw_range,
  input  logic                     point_is_obstacle,
  input  logic [FRAME_W-1:0]       frame_count,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     updated,
  output logic                     cell_obstacle,
  output logic signed [H_W-1:0]    cell_min_cm,
  output logic signed [H_W-1:0]    cell_max_cm,
  output logic [CNT_W-1:0]         cell_hits,
  output logic [CNT_W-1:0]         cell_seen
);

  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_not_empty;
  point_t       q_data;
  point_t       q_head;
  back_status_t status;

  chol_front #(.CELL_COUNT(CELL_COUNT), .BEAM_COUNT(BEAM_COUNT)) u_front (
    .rst, .in_valid, .in_stall, .cell_index, .cell_found, .beam_number,
    .point_valid, .point_z_cm, .vehicle_z_cm, .raw_range, .point_is_obstacle,
    .frame_count, .q_full, .status, .q_push, .q_data
  );

  chol_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_data), .pop(q_pop),
    .full(q_full), .not_empty(q_not_empty), .head(q_head)
  );

  chol_back #(.CELL_COUNT(CELL_COUNT)) u_back (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .q_not_empty, .q_head, .q_pop, .status, .out_valid, .out_stall,
    .updated, .cell_obstacle, .cell_min_cm, .cell_max_cm, .cell_hits, .cell_seen
  );

endmodule

/* src/chol_front.sv */
// Front part: accepts points and classifies them before queuing.
module chol_front import chol_pkg::*; #(
  parameter int CELL_COUNT = 16384,
  parameter int BEAM_COUNT = 64
) (
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [IDX_W-1:0]         cell_index,
  input  logic                     cell_found,
  input  logic [BEAM_W-1:0]        beam_number,
  input  logic                     point_valid,
  input  logic signed [Z_W-1:0]    point_z_cm,
  input  logic signed [Z_W-1:0]    vehicle_z_cm,
  input  logic [RANGE_W-1:0]       raw_range,
  input  logic                     point_is_obstacle,
  input  logic [FRAME_W-1:0]       frame_count,
  input  logic                     q_full,
  input  back_status_t             status,
  output logic                     q_push,
  output point_t                   q_data
);

  logic signed [H_W-1:0] z;
  logic                  in_band;
  logic                  beam_ok;

  assign z       = H_W'(point_z_cm) + H_W'(vehicle_z_cm);
  assign in_band = (z > BAND_LOW) && (z < BAND_HIGH);
  assign beam_ok = 32'(beam_number) < 32'(BEAM_COUNT - 1);

  assign in_stall = rst || q_full || status.clearing;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    q_data.addr_ok    = cell_found && (32'(cell_index) < 32'(CELL_COUNT));
    q_data.upd_ok     = point_valid && beam_ok && in_band;
    q_data.cell_index = cell_index;
    q_data.z          = z;
    q_data.range_ok   = raw_range > MIN_RANGE;
    q_data.pobs       = point_is_obstacle;
    q_data.frame      = frame_count;
  end

endmodule

/* src/chol_queue.sv */
// Two-entry queue between the front and back parts.
module chol_queue import chol_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  point_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output point_t head
);

  point_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* src/chol_back.sv */
// Back part: cell memory, read-modify-write of each cell and the result register.
module chol_back import chol_pkg::*; #(
  parameter int CELL_COUNT = 16384
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     q_not_empty,
  input  point_t                   q_head,
  output logic                     q_pop,
  output back_status_t             status,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     updated,
  output logic                     cell_obstacle,
  output logic signed [H_W-1:0]    cell_min_cm,
  output logic signed [H_W-1:0]    cell_max_cm,
  output logic [CNT_W-1:0]         cell_hits,
  output logic [CNT_W-1:0]         cell_seen
);

  localparam int ADDR_W = $clog2(CELL_COUNT);

  cell_t              mem [CELL_COUNT];
  cell_t              rd_data;
  cell_t              wr_data;
  cell_t              upd_cell;
  logic [ADDR_W-1:0]  wr_addr;
  logic               we;
  logic [ADDR_W-1:0]  clr_cnt;
  logic               clr_done;

  back_state_t state;
  back_state_t state_next;
  logic        load;
  point_t      cur;

  logic [CFG_W-1:0] obst_h;
  logic [CFG_W-1:0] over_h;
  logic             force_obst;

  logic signed [H_W-1:0] nmin;
  logic signed [H_W-1:0] nmax;
  logic signed [H_W:0]   spread;
  logic signed [H_W:0]   rise;
  logic [CNT_W:0]        hsum;
  logic [CNT_W:0]        ssum;
  logic                  out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      obst_h     <= OBST_RESET;
      over_h     <= OVER_RESET;
      force_obst <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OBSTACLE_HEIGHT: obst_h     <= cfg_data;
        REG_OVERPASS_HEIGHT: over_h     <= cfg_data;
        REG_FORCE_OBSTACLE:  force_obst <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign clr_done = clr_cnt == ADDR_W'(CELL_COUNT - 1);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_done) state_next = ST_IDLE;
      ST_IDLE:  if (q_not_empty && out_free) state_next = ST_CALC;
      ST_CALC:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    status.clearing = 1'b0;
    q_pop           = 1'b0;
    load            = 1'b0;
    case (state)
      ST_CLEAR: status.clearing = 1'b1;
      ST_IDLE:  q_pop = q_not_empty && out_free;
      ST_CALC:  load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (status.clearing) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_head;
      rd_data <= mem[ADDR_W'(q_head.cell_index)];
    end
  end

  always_comb begin
    upd_cell = rd_data;
    nmin     = (rd_data.min_h > cur.z) ? cur.z : rd_data.min_h;
    nmax     = (cur.z > rd_data.max_h) ? cur.z : rd_data.max_h;
    spread   = (H_W+1)'(nmax) - (H_W+1)'(nmin);
    rise     = (H_W+1)'(cur.z) - (H_W+1)'(nmin);
    hsum     = {1'b0, rd_data.hits} + HIT_STEP;
    ssum     = {1'b0, rd_data.seen} + 1'b1;
    if (cur.upd_ok) begin
      upd_cell.min_h = nmin;
      upd_cell.max_h = nmax;
      if (spread > $signed({8'b0, obst_h}) || force_obst) upd_cell.obst = 1'b1;
      if (rd_data.last_frame != cur.frame && rise < $signed({8'b0, over_h})
          && cur.range_ok) begin
        if (cur.pobs || force_obst) begin
          upd_cell.obst       = 1'b1;
          upd_cell.last_frame = cur.frame;
          upd_cell.hits       = hsum[CNT_W] ? '1 : hsum[CNT_W-1:0];
        end else begin
          upd_cell.seen = ssum[CNT_W] ? '1 : ssum[CNT_W-1:0];
        end
      end
    end
  end

  assign we      = status.clearing || (load && cur.addr_ok);
  assign wr_addr = status.clearing ? clr_cnt : ADDR_W'(cur.cell_index);
  assign wr_data = status.clearing ? CELL_RESET : upd_cell;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cur.addr_ok) begin
        updated       <= cur.upd_ok;
        cell_obstacle <= upd_cell.obst;
        cell_min_cm   <= upd_cell.min_h;
        cell_max_cm   <= upd_cell.max_h;
        cell_hits     <= upd_cell.hits;
        cell_seen     <= upd_cell.seen;
      end else begin
        updated       <= 1'b0;
        cell_obstacle <= 1'b0;
        cell_min_cm   <= '0;
        cell_max_cm   <= '0;
        cell_hits     <= '0;
        cell_seen     <= '0;
      end
    end
  end

endmodule

/* src/chol_checker.sv */
// Port-level checks for the labeler, bound to its top level.
module chol_checker import chol_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  updated,
  input logic                  cell_obstacle,
  input logic signed [H_W-1:0] cell_min_cm,
  input logic signed [H_W-1:0] cell_max_cm,
  input logic [CNT_W-1:0]      cell_hits
);

  a_sweep_stall: assert property (@(posedge clk) $past(rst) |-> in_stall)
    else $error("points accepted right after reset");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && updated |-> cell_min_cm <= cell_max_cm)
    else $error("updated cell has minimum above maximum");

  a_hits_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cell_obstacle |-> cell_hits == '0)
    else $error("cell with hits is not marked as obstacle");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_hits) && $stable(cell_min_cm))
    else $error("stalled result changed");

endmodule

bind cell_height_obstacle_labeler_top chol_checker u_chol_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .updated, .cell_obstacle,
  .cell_min_cm, .cell_max_cm, .cell_hits
);
